[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication, disabled while reset is high.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/sses_pkg.sv]
// Types and constants for the spectral strain energy split.
`default_nettype none

package sses_pkg;

  localparam int STRAIN_W        = 32;
  localparam int ENERGY_W        = 64;
  localparam int ENERGY_FRAC_BITS = 24;
  localparam int RAD_W           = 66;
  localparam int ROOT_W          = 33;
  localparam int REM_W           = 35;
  localparam int MEAN_W          = 33;
  localparam int TRACE_W         = 35;
  localparam int MAG_W           = 34;
  localparam int SQ_W            = 68;
  localparam int SQSUM_W         = 70;
  localparam int TOTAL_W         = 105;
  localparam int FRONT_LAT       = 4;
  localparam int SQRT_LAT        = ROOT_W;
  localparam int ENERGY_LAT      = 7;

  localparam logic REG_LAME  = 1'b0;
  localparam logic REG_SHEAR = 1'b1;

  typedef struct packed {
    logic signed [STRAIN_W-1:0] strain_rr;
    logic signed [STRAIN_W-1:0] strain_zz;
    logic signed [STRAIN_W-1:0] strain_hoop;
    logic signed [STRAIN_W-1:0] strain_rz_eng;
    logic                       batch_end;
  } in_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy_tensile;
    logic [ENERGY_W-1:0] energy_compressive;
    logic                batch_end_out;
  } out_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0]  mean;
    logic signed [MEAN_W-1:0]  hoop2;
    logic signed [TRACE_W-1:0] trace;
    logic                      batch_end;
  } side_t;

  function automatic logic [MAG_W-1:0] pos_mag(input logic signed [TRACE_W-1:0] v);
    logic [MAG_W-1:0] m;
    m = (!v[TRACE_W-1] && (v != '0)) ? v[MAG_W-1:0] : '0;
    return m;
  endfunction

  function automatic logic [MAG_W-1:0] neg_mag(input logic signed [TRACE_W-1:0] v);
    logic [TRACE_W-1:0] n;
    n = -v;
    return v[TRACE_W-1] ? n[MAG_W-1:0] : '0;
  endfunction

endpackage

`default_nettype wire

[rtl/spectral_strain_energy_split.sv]
// Accepts one transaction per cycle.
// Depth is set by the 33-stage square root (one root bit per stage) plus front and energy stages.
// busy is always low; results are strobed for one cycle and cannot be held off.
// Synchronous reset clears the pipeline valid bits and both moduli to zero.
`default_nettype none
`include "assert_macros.svh"

module spectral_strain_energy_split #(
  parameter int STRAIN_FRAC_BITS = 28
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire sses_pkg::in_t  item,
  output logic                result_valid,
  output sses_pkg::out_t      result,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic           cfg_index,
  input  wire logic [31:0]    cfg_data
);

  logic [31:0]                    lame_lambda;
  logic [31:0]                    shear_modulus;
  logic                           front_valid;
  logic [sses_pkg::RAD_W-1:0]     rad2;
  sses_pkg::side_t                front_side;
  logic                           sqrt_valid;
  logic [sses_pkg::ROOT_W-1:0]    root;
  sses_pkg::side_t                sqrt_side;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lame_lambda   <= '0;
      shear_modulus <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sses_pkg::REG_LAME:  lame_lambda   <= cfg_data;
        sses_pkg::REG_SHEAR: shear_modulus <= cfg_data;
        default: ;
      endcase
    end
  end

  sses_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .item     (item),
    .out_valid(front_valid),
    .rad2     (rad2),
    .side     (front_side)
  );

  sses_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .rad2     (rad2),
    .side_in  (front_side),
    .out_valid(sqrt_valid),
    .root     (root),
    .side_out (sqrt_side)
  );

  sses_energy #(
    .STRAIN_FRAC_BITS(STRAIN_FRAC_BITS)
  ) u_energy (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (sqrt_valid),
    .root         (root),
    .side         (sqrt_side),
    .lame_lambda  (lame_lambda),
    .shear_modulus(shear_modulus),
    .out_valid    (result_valid),
    .result       (result)
  );

  `ASSERT_IMPLY(a_sqrt_chain, $past(front_valid, sses_pkg::SQRT_LAT), sqrt_valid, "sqrt valid lost")
  `ASSERT_IMPLY(a_energy_chain, $past(sqrt_valid, sses_pkg::ENERGY_LAT), result_valid, "energy valid lost")
  `ASSERT_IMPLY(a_zero_moduli, result_valid && lame_lambda == '0 && shear_modulus == '0, result.energy_tensile == '0 && result.energy_compressive == '0, "nonzero energy with zero moduli")

endmodule

`default_nettype wire

[rtl/sses_front.sv]
// Front stages: input register, difference/mean/trace, squares, radius squared.
`default_nettype none

module sses_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire sses_pkg::in_t                       item,
  output logic                                     out_valid,
  output logic [sses_pkg::RAD_W-1:0]               rad2,
  output sses_pkg::side_t                          side
);

  logic                              a_valid;
  sses_pkg::in_t                     a_item;
  logic                              b_valid;
  logic [sses_pkg::MAG_W-2:0]        b_dmag;
  logic [sses_pkg::STRAIN_W-1:0]     b_emag;
  sses_pkg::side_t                   b_side;
  logic                              c_valid;
  logic [sses_pkg::RAD_W-1:0]        c_dsq;
  logic [2*sses_pkg::STRAIN_W-1:0]   c_esq;
  sses_pkg::side_t                   c_side;

  logic signed [sses_pkg::MEAN_W-1:0]  diff;
  logic signed [sses_pkg::MEAN_W-1:0]  diff_neg;
  logic signed [sses_pkg::STRAIN_W-1:0] shear_neg;
  logic signed [sses_pkg::MEAN_W:0]    sum3;
  sses_pkg::side_t                     side_next;

  always_comb begin
    diff      = {a_item.strain_rr[31], a_item.strain_rr} - {a_item.strain_zz[31], a_item.strain_zz};
    diff_neg  = -diff;
    shear_neg = -a_item.strain_rz_eng;
    sum3      = {{2{a_item.strain_rr[31]}}, a_item.strain_rr}
              + {{2{a_item.strain_zz[31]}}, a_item.strain_zz}
              + {{2{a_item.strain_hoop[31]}}, a_item.strain_hoop};
    side_next.mean      = {a_item.strain_rr[31], a_item.strain_rr}
                        + {a_item.strain_zz[31], a_item.strain_zz};
    side_next.hoop2     = {a_item.strain_hoop, 1'b0};
    side_next.trace     = {sum3, 1'b0};
    side_next.batch_end = a_item.batch_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_item <= item;
    b_dmag <= diff[sses_pkg::MEAN_W-1] ? diff_neg : diff;
    b_emag <= a_item.strain_rz_eng[31] ? shear_neg : a_item.strain_rz_eng;
    b_side <= side_next;
    c_dsq  <= sses_pkg::RAD_W'(b_dmag) * sses_pkg::RAD_W'(b_dmag);
    c_esq  <= (2*sses_pkg::STRAIN_W)'(b_emag) * (2*sses_pkg::STRAIN_W)'(b_emag);
    c_side <= b_side;
    rad2   <= c_dsq + sses_pkg::RAD_W'(c_esq);
    side   <= c_side;
  end

endmodule

`default_nettype wire

[rtl/sses_sqrt.sv]
// Pipelined floor square root, one result bit per stage.
`default_nettype none

module sses_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [sses_pkg::RAD_W-1:0]   rad2,
  input  wire sses_pkg::side_t              side_in,
  output logic                              out_valid,
  output logic [sses_pkg::ROOT_W-1:0]       root,
  output sses_pkg::side_t                   side_out
);

  localparam int N = sses_pkg::ROOT_W;

  logic                            vld_s  [0:N];
  logic [sses_pkg::RAD_W-1:0]      v_s    [0:N];
  logic [sses_pkg::ROOT_W-1:0]     root_s [0:N];
  logic [sses_pkg::REM_W-1:0]      rem_s  [0:N];
  sses_pkg::side_t                 side_s [0:N];

  assign vld_s[0]  = in_valid;
  assign v_s[0]    = rad2;
  assign root_s[0] = '0;
  assign rem_s[0]  = '0;
  assign side_s[0] = side_in;

  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic [sses_pkg::REM_W-1:0] rem_in;
    logic [sses_pkg::REM_W-1:0] trial;
    logic                       ge;

    always_comb begin
      rem_in = {rem_s[k-1][sses_pkg::REM_W-3:0], v_s[k-1][sses_pkg::RAD_W-1 -: 2]};
      trial  = {root_s[k-1], 2'b01};
      ge     = (rem_in >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k] <= 1'b0;
      end else begin
        vld_s[k] <= vld_s[k-1];
      end
    end

    always_ff @(posedge clk) begin
      v_s[k]    <= {v_s[k-1][sses_pkg::RAD_W-3:0], 2'b00};
      root_s[k] <= {root_s[k-1][sses_pkg::ROOT_W-2:0], ge};
      rem_s[k]  <= ge ? (rem_in - trial) : rem_in;
      side_s[k] <= side_s[k-1];
    end
  end

  assign out_valid = vld_s[N];
  assign root      = root_s[N];
  assign side_out  = side_s[N];

endmodule

`default_nettype wire

[rtl/sses_energy.sv]
// Principal values, split magnitudes, squares, modulus scaling, shift and saturation.
`default_nettype none

module sses_energy #(
  parameter int STRAIN_FRAC_BITS = 28
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [sses_pkg::ROOT_W-1:0] root,
  input  wire sses_pkg::side_t             side,
  input  wire logic [31:0]                 lame_lambda,
  input  wire logic [31:0]                 shear_modulus,
  output logic                             out_valid,
  output sses_pkg::out_t                   result
);

  localparam int SHIFT = 2*STRAIN_FRAC_BITS + 3 - sses_pkg::ENERGY_FRAC_BITS;
  localparam int TW    = sses_pkg::TOTAL_W;
  localparam int EW    = sses_pkg::ENERGY_W;

  logic [sses_pkg::ENERGY_LAT-1:1] vld;
  logic [sses_pkg::ENERGY_LAT-1:1] be;

  logic signed [sses_pkg::TRACE_W-1:0] mean_x;
  logic signed [sses_pkg::TRACE_W-1:0] root_x;
  logic signed [sses_pkg::TRACE_W-1:0] ev0;
  logic signed [sses_pkg::TRACE_W-1:0] ev1;
  logic signed [sses_pkg::TRACE_W-1:0] ev2;

  logic [sses_pkg::MAG_W-1:0]   e1_mag [0:7];
  logic [sses_pkg::SQ_W-1:0]    e2_sq  [0:7];
  logic [sses_pkg::SQSUM_W-1:0] e3_sqp, e3_sqn;
  logic [sses_pkg::SQ_W-1:0]    e3_tp, e3_tn;
  logic [65:0]                  e4_lp_lo, e4_lp_hi, e4_ln_lo, e4_ln_hi;
  logic [67:0]                  e4_gp_lo, e4_gp_hi, e4_gn_lo, e4_gn_hi;
  logic [99:0]                  e5_lp, e5_ln;
  logic [102:0]                 e5_gp, e5_gn;
  logic [TW-1:0]                e6_tp, e6_tn;
  logic [TW-1:0]                sh_p, sh_n;
  logic [32:0]                  g2;

  always_comb begin
    mean_x = {{2{side.mean[sses_pkg::MEAN_W-1]}}, side.mean};
    root_x = {2'b00, root};
    ev0    = mean_x + root_x;
    ev1    = mean_x - root_x;
    ev2    = {{2{side.hoop2[sses_pkg::MEAN_W-1]}}, side.hoop2};
    g2     = {shear_modulus, 1'b0};
    sh_p   = e6_tp >> SHIFT;
    sh_n   = e6_tn >> SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[sses_pkg::ENERGY_LAT-2:1], in_valid};
      out_valid <= vld[sses_pkg::ENERGY_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    be <= {be[sses_pkg::ENERGY_LAT-2:1], side.batch_end};
    e1_mag[0] <= sses_pkg::pos_mag(ev0);
    e1_mag[1] <= sses_pkg::pos_mag(ev1);
    e1_mag[2] <= sses_pkg::pos_mag(ev2);
    e1_mag[3] <= sses_pkg::neg_mag(ev0);
    e1_mag[4] <= sses_pkg::neg_mag(ev1);
    e1_mag[5] <= sses_pkg::neg_mag(ev2);
    e1_mag[6] <= sses_pkg::pos_mag(side.trace);
    e1_mag[7] <= sses_pkg::neg_mag(side.trace);
    for (int i = 0; i < 8; i++) begin
      e2_sq[i] <= sses_pkg::SQ_W'(e1_mag[i]) * sses_pkg::SQ_W'(e1_mag[i]);
    end
    e3_sqp <= sses_pkg::SQSUM_W'(e2_sq[0]) + sses_pkg::SQSUM_W'(e2_sq[1])
            + sses_pkg::SQSUM_W'(e2_sq[2]);
    e3_sqn <= sses_pkg::SQSUM_W'(e2_sq[3]) + sses_pkg::SQSUM_W'(e2_sq[4])
            + sses_pkg::SQSUM_W'(e2_sq[5]);
    e3_tp  <= e2_sq[6];
    e3_tn  <= e2_sq[7];
    e4_lp_lo <= 66'(e3_tp[33:0]) * 66'(lame_lambda);
    e4_lp_hi <= 66'(e3_tp[67:34]) * 66'(lame_lambda);
    e4_ln_lo <= 66'(e3_tn[33:0]) * 66'(lame_lambda);
    e4_ln_hi <= 66'(e3_tn[67:34]) * 66'(lame_lambda);
    e4_gp_lo <= 68'(e3_sqp[34:0]) * 68'(g2);
    e4_gp_hi <= 68'(e3_sqp[69:35]) * 68'(g2);
    e4_gn_lo <= 68'(e3_sqn[34:0]) * 68'(g2);
    e4_gn_hi <= 68'(e3_sqn[69:35]) * 68'(g2);
    e5_lp <= 100'(e4_lp_lo) + {e4_lp_hi, 34'b0};
    e5_ln <= 100'(e4_ln_lo) + {e4_ln_hi, 34'b0};
    e5_gp <= 103'(e4_gp_lo) + {e4_gp_hi, 35'b0};
    e5_gn <= 103'(e4_gn_lo) + {e4_gn_hi, 35'b0};
    e6_tp <= TW'(e5_lp) + TW'(e5_gp);
    e6_tn <= TW'(e5_ln) + TW'(e5_gn);
    result.energy_tensile     <= (|sh_p[TW-1:EW]) ? '1 : sh_p[EW-1:0];
    result.energy_compressive <= (|sh_n[TW-1:EW]) ? '1 : sh_n[EW-1:0];
    result.batch_end_out      <= be[sses_pkg::ENERGY_LAT-1];
  end

endmodule

`default_nettype wire
